// ----- design/dna_core_string_bucketer_macros.svh -----
// assertion macros shared by the bucketer checker
`ifndef DNA_CORE_STRING_BUCKETER_MACROS_SVH
`define DNA_CORE_STRING_BUCKETER_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define DCSB_CHECK_NOW(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define DCSB_CHECK_NEXT(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/dcsb_pkg.sv -----
// shared types, constants and helpers of the dna core string bucketer
package dcsb_pkg;

   localparam int NODE_W     = 10;
   localparam int NODE_COUNT = 2 ** NODE_W;
   localparam int DEPTH_W    = 6;
   localparam int MAX_DEPTH  = 32;
   localparam int COUNT_W    = 32;

   localparam int OUT_DEPTH  = 8;
   localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W  = OUT_PTR_W + 1;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [DEPTH_W-1:0] level_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [3:0][NODE_W-1:0] goto_type;

   localparam node_type  NODE_LAST = node_type'(NODE_COUNT - 1);
   localparam level_type LEVEL_MAX = level_type'(MAX_DEPTH);
   localparam count_type COUNT_MAX = '1;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_BASE = 1'b1
   } func_type;

   typedef struct packed {
      node_type node;
      logic     matched;
   } rsp_type;

   function automatic count_type sat_inc(input count_type value);
      count_type result;
      begin
         result = (value == COUNT_MAX) ? value : value + count_type'(1);
         return result;
      end
   endfunction

endpackage

// ----- design/dcsb_rsp_fifo.sv -----
// result queue between the bucket update stage and the response channel
module dcsb_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  dcsb_pkg::rsp_type push_data,
   input  logic              pop_ready,
   output logic              pop_valid,
   output dcsb_pkg::rsp_type pop_data
);
   import dcsb_pkg::*;

   rsp_type                entries_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff;
   logic [OUT_PTR_W-1:0]   rd_ptr_ff;
   logic [OUT_CNT_W-1:0]   cnt_ff;
   logic [OUT_CNT_W-1:0]   cnt_in;
   logic                   pop;

   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push_valid && !pop) begin
         cnt_in = cnt_ff + OUT_CNT_W'(1);
      end else if (!push_valid && pop) begin
         cnt_in = cnt_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/dna_core_string_bucketer.sv -----
// dna core string bucketer: aho-corasick walk over dna reads with bucket counters
//
// req channel carries two kinds of transfer, chosen by func in req_tuser:
// a load writes one automaton node (four next nodes, output link, depth),
// a base steps the walk; tlast marks the final base of a read.
// rsp channel gives one transfer per read: the best bucket node and a matched
// flag; that node's bucket counter is incremented, saturating.
// throughput: one request per cycle, sustained while req_tready is high, loads and bases mixed freely.
// a final base passes the stage b, c, d and e registers and then the result
// queue before its read's result shows on rsp_tvalid.
// the walk runs through four synchronous memories in a five stage pipeline:
// goto read, link read, count and level read, best compare, counter update.
// the goto read of one base addresses from the previous base's read data.
// results queue in an eight entry buffer; req_tready drops while eight reads
// are accepted but not yet delivered, so a stalled rsp side backs up req.
// reset: synchronous; afterwards a clearing pass zeroes the 1024 bucket
// counters, one per cycle, and req_tready stays low until the pass ends.
// node tables hold no defined value until loaded.
module dna_core_string_bucketer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // node, next_a, next_c, next_g, next_t, link_valid, link_node, depth_level,
   // base, zero fill
   input  logic [dcsb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func, is_unknown
   input  logic [dcsb_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // bucket_node, zero fill
   output logic [dcsb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // matched
   output logic                              rsp_tuser
);
   import dcsb_pkg::*;

   // request fields
   node_type   in_node;
   goto_type   in_next;
   logic       in_link_vld;
   node_type   in_link_node;
   level_type  in_depth;
   logic [1:0] in_base;
   func_type   in_func;
   logic       in_unk;
   logic       accept;
   logic       a_base;
   logic       a_load;

   // memories
   goto_type          goto_mem  [NODE_COUNT];
   logic [NODE_W:0]   link_mem  [NODE_COUNT];
   level_type         level_mem [NODE_COUNT];
   count_type         count_mem [NODE_COUNT];

   goto_type          goto_rd_ff;
   logic [NODE_W:0]   link_rd_ff;
   level_type         lvl_rd_ff;
   count_type         cnt_rd_ff;

   // walk position
   node_type   cur_ff;
   node_type   cur_in;
   node_type   walk_node;

   // stage b
   logic            b_base_ff;
   logic            b_load_ff;
   logic            b_unk_ff;
   logic            b_last_ff;
   logic [1:0]      b_sel_ff;
   node_type        b_node_ff;
   logic [NODE_W:0] b_link_ff;
   level_type       b_depth_ff;

   // stage c
   logic       c_base_ff;
   logic       c_load_ff;
   logic       c_unk_ff;
   logic       c_last_ff;
   node_type   c_node_ff;
   level_type  c_depth_ff;
   level_type  c_depth_clamp;
   logic       c_cons;
   node_type   c_x;

   // stage d
   logic       d_base_ff;
   logic       d_cons_ff;
   logic       d_last_ff;
   node_type   d_x_ff;
   count_type  x_cnt;
   logic       take;
   logic       nb_vld;
   node_type   nb_node;
   count_type  nb_cnt;
   level_type  nb_lvl;
   node_type   lvl_node;
   level_type  best_lvl_in;
   count_type  root_eff;
   count_type  e_inc_in;

   // best candidate of the current read
   logic       best_vld_ff;
   node_type   best_node_ff;
   count_type  best_cnt_ff;
   level_type  best_lvl_ff;

   // stage e
   logic       e_vld_ff;
   node_type   e_node_ff;
   logic       e_hit_ff;
   count_type  e_inc_ff;

   // counter write bypass and root counter copy
   logic       fw_vld_ff;
   node_type   fw_node_ff;
   count_type  fw_cnt_ff;
   count_type  root_cnt_ff;

   // counter clearing pass
   logic       clr_busy_ff;
   node_type   clr_addr_ff;
   logic       cnt_we;
   node_type   cnt_wa;
   count_type  cnt_wd;

   // results accepted but not delivered
   logic [OUT_CNT_W-1:0] res_ff;
   logic [OUT_CNT_W-1:0] res_in;
   logic                 acc_last;
   logic                 rsp_xfer;

   rsp_type    push_data;
   rsp_type    head;

   assign in_node      = req_tdata[9:0];
   assign in_next      = goto_type'(req_tdata[49:10]);
   assign in_link_vld  = req_tdata[50];
   assign in_link_node = req_tdata[60:51];
   assign in_depth     = req_tdata[66:61];
   assign in_base      = req_tdata[68:67];
   assign in_func      = func_type'(req_tuser[0]);
   assign in_unk       = req_tuser[1];

   assign req_tready = !clr_busy_ff && (res_ff < OUT_CNT_W'(OUT_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign a_base     = accept && (in_func == FUNC_BASE);
   assign a_load     = accept && (in_func == FUNC_LOAD);
   assign acc_last   = a_base && req_tlast;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // stage a: goto access, address follows the base one stage ahead
   assign walk_node = goto_rd_ff[b_sel_ff];

   always_comb begin
      cur_in = cur_ff;
      if (b_base_ff) begin
         cur_in = (b_unk_ff || b_last_ff) ? '0 : walk_node;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         goto_mem[in_node] <= in_next;
      end
      goto_rd_ff <= goto_mem[cur_in];
   end

   // stage b: link access
   always_ff @(posedge clock) begin
      if (b_load_ff) begin
         link_mem[b_node_ff] <= b_link_ff;
      end
      link_rd_ff <= link_mem[walk_node];
   end

   // stage c: level and count access at the linked output node
   assign c_cons        = c_base_ff && !c_unk_ff && link_rd_ff[NODE_W];
   assign c_x           = link_rd_ff[NODE_W-1:0];
   assign c_depth_clamp = (c_depth_ff > LEVEL_MAX) ? LEVEL_MAX : c_depth_ff;

   always_ff @(posedge clock) begin
      if (c_load_ff) begin
         level_mem[c_node_ff] <= c_depth_clamp;
      end
      lvl_rd_ff <= level_mem[c_x];
   end

   assign cnt_we = clr_busy_ff || e_vld_ff;
   assign cnt_wa = clr_busy_ff ? clr_addr_ff : e_node_ff;
   assign cnt_wd = clr_busy_ff ? '0 : e_inc_ff;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= count_mem[c_x];
   end

   // stage d: best match compare
   always_comb begin
      if (e_vld_ff && (e_node_ff == d_x_ff)) begin
         x_cnt = e_inc_ff;
      end else if (fw_vld_ff && (fw_node_ff == d_x_ff)) begin
         x_cnt = fw_cnt_ff;
      end else begin
         x_cnt = cnt_rd_ff;
      end
      root_eff = (e_vld_ff && (e_node_ff == '0)) ? e_inc_ff : root_cnt_ff;
      take = d_cons_ff && (!best_vld_ff || (best_cnt_ff < x_cnt) ||
             ((best_cnt_ff == x_cnt) && (best_lvl_ff < lvl_rd_ff)));
      nb_vld  = best_vld_ff || d_cons_ff;
      nb_node = take ? d_x_ff    : best_node_ff;
      nb_cnt  = take ? x_cnt     : best_cnt_ff;
      nb_lvl  = take ? lvl_rd_ff : best_lvl_ff;
      // a load of the best node refreshes its held depth
      lvl_node    = d_base_ff ? nb_node : best_node_ff;
      best_lvl_in = d_base_ff ? nb_lvl : best_lvl_ff;
      if (c_load_ff && (c_node_ff == lvl_node)) begin
         best_lvl_in = c_depth_clamp;
      end
      if (take) begin
         e_inc_in = sat_inc(x_cnt);
      end else if (best_vld_ff) begin
         e_inc_in = sat_inc(best_cnt_ff);
      end else begin
         e_inc_in = sat_inc(root_eff);
      end
   end

   always_comb begin
      res_in = res_ff;
      if (acc_last && !rsp_xfer) begin
         res_in = res_ff + OUT_CNT_W'(1);
      end else if (!acc_last && rsp_xfer) begin
         res_in = res_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         b_base_ff   <= 1'b0;
         b_load_ff   <= 1'b0;
         c_base_ff   <= 1'b0;
         c_load_ff   <= 1'b0;
         d_base_ff   <= 1'b0;
         d_cons_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
         e_vld_ff    <= 1'b0;
         fw_vld_ff   <= 1'b0;
         root_cnt_ff <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         res_ff      <= '0;
      end else begin
         cur_ff    <= cur_in;
         b_base_ff <= a_base;
         b_load_ff <= a_load;
         c_base_ff <= b_base_ff;
         c_load_ff <= b_load_ff;
         d_base_ff <= c_base_ff;
         d_cons_ff <= c_cons;
         e_vld_ff  <= d_base_ff && d_last_ff;
         fw_vld_ff <= e_vld_ff;
         if (d_base_ff) begin
            best_vld_ff <= nb_vld && !d_last_ff;
         end
         if (e_vld_ff && (e_node_ff == '0)) begin
            root_cnt_ff <= e_inc_ff;
         end
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + node_type'(1);
            if (clr_addr_ff == NODE_LAST) begin
               clr_busy_ff <= 1'b0;
            end
         end
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      b_unk_ff   <= in_unk;
      b_last_ff  <= req_tlast;
      b_sel_ff   <= in_base;
      b_node_ff  <= in_node;
      b_link_ff  <= {in_link_vld, in_link_node};
      b_depth_ff <= in_depth;
      c_unk_ff   <= b_unk_ff;
      c_last_ff  <= b_last_ff;
      c_node_ff  <= b_node_ff;
      c_depth_ff <= b_depth_ff;
      d_last_ff  <= c_last_ff;
      d_x_ff     <= c_x;
      if (d_base_ff) begin
         best_node_ff <= nb_node;
         best_cnt_ff  <= nb_cnt;
      end
      best_lvl_ff <= best_lvl_in;
      e_node_ff  <= nb_vld ? nb_node : '0;
      e_hit_ff   <= nb_vld;
      e_inc_ff   <= e_inc_in;
      fw_node_ff <= e_node_ff;
      fw_cnt_ff  <= e_inc_ff;
   end

   // stage e: result into the queue
   assign push_data.node    = e_node_ff;
   assign push_data.matched = e_hit_ff;

   dcsb_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (e_vld_ff),
      .push_data  (push_data),
      .pop_ready  (rsp_tready),
      .pop_valid  (rsp_tvalid),
      .pop_data   (head)
   );

   assign rsp_tdata = {{(RSP_DATA_W - NODE_W){1'b0}}, head.node};
   assign rsp_tuser = head.matched;

endmodule

// ----- design/dcsb_checker.sv -----
// port level checks of the dna core string bucketer, bound to the top level
`include "dna_core_string_bucketer_macros.svh"

module dcsb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [dcsb_pkg::REQ_USER_W-1:0]   req_tuser,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [dcsb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser
);
   import dcsb_pkg::*;

   logic [OUT_CNT_W-1:0] pend_ff;
   logic [OUT_CNT_W-1:0] pend_in;
   logic                 last_in;
   logic                 rsp_out;

   assign last_in = req_tvalid && req_tready && req_tlast && (req_tuser[0] == FUNC_BASE);
   assign rsp_out = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (last_in && !rsp_out) begin
         pend_in = pend_ff + OUT_CNT_W'(1);
      end else if (!last_in && rsp_out) begin
         pend_in = pend_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `DCSB_CHECK_NEXT(a_reset_blocks_req, 1'b0, reset, !req_tready, "req ready after reset")
   `DCSB_CHECK_NOW(a_rsp_needs_read, reset, rsp_tvalid, pend_ff != '0, "result without read")
   `DCSB_CHECK_NOW(a_ready_has_room, reset, req_tready, pend_ff < OUT_CNT_W'(OUT_DEPTH), "no room")
   `DCSB_CHECK_NOW(a_unmatched_root, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "not root")
   `DCSB_CHECK_NEXT(a_rsp_held, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")

endmodule

bind dna_core_string_bucketer dcsb_checker u_dcsb_checker (.*);
